// ===== rtl/core/sbc_pkg.sv =====
// Shared types and constants for the synteny block chainer.
`timescale 1ns / 1ps
`default_nettype none

package sbc_pkg;

    localparam int SET_BITS = 16;

    // Result of comparing the incoming block against one chain end
    typedef struct packed {
        logic adj;   // next block of this chain
        logic far;   // query gap above one
    } sbc_cmp_t;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RD   = 5'b00010,
        S_EV   = 5'b00100,
        S_FIN  = 5'b01000,
        S_DONE = 5'b10000
    } sbc_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/sbc_list_ram.sv =====
// Chain list storage: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module sbc_list_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 81,
    parameter int AW    = 6
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sbc_match.sv =====
// Adjacency and query-gap test of a block against one chain end.
`timescale 1ns / 1ps
`default_nettype none

module sbc_match #(
    parameter int GROUP_BITS = 24
) (
    input  wire logic [GROUP_BITS-1:0] qg,
    input  wire logic [GROUP_BITS-1:0] tg,
    input  wire logic                  rev,
    input  wire logic [GROUP_BITS-1:0] eq,
    input  wire logic [GROUP_BITS-1:0] et,
    input  wire logic                  es,
    output sbc_pkg::sbc_cmp_t          cmp
);
    import sbc_pkg::*;

    logic [GROUP_BITS:0] qx, eqp1, tx, etx, tp1, etp1;

    // one extra bit so the +1 never wraps
    assign qx   = {1'b0, qg};
    assign eqp1 = {1'b0, eq} + {{GROUP_BITS{1'b0}}, 1'b1};
    assign tx   = {1'b0, tg};
    assign etx  = {1'b0, et};
    assign tp1  = tx + {{GROUP_BITS{1'b0}}, 1'b1};
    assign etp1 = etx + {{GROUP_BITS{1'b0}}, 1'b1};

    always_comb
    begin
        cmp.far = (qx > eqp1);
        cmp.adj = (qx == eqp1) && (rev == es) &&
                  ((!rev && tx == etp1) || (rev && tp1 == etx));
    end

endmodule

`default_nettype wire

// ===== rtl/core/synteny_block_chainer_core.sv =====
// Top level of the synteny block chainer: walk control, list RAM and result register.
//
// Each input word is one aligned block; one result word comes out per block. The block
// walks the open chain list held in a single-port-read RAM after an accept state, each
// stored entry in a read state and then an evaluate state that writes it back in
// compacted order, then finish and hand-off states. Entries before a match with a query
// gap above one, other than the last entry, are squeezed out on the way. One item is worked
// at a time; a finished result waits in the output register while the next word is taken.
`timescale 1ns / 1ps
`default_nettype none

module synteny_block_chainer_core #(
    parameter int LIST_DEPTH = 64,
    parameter int GROUP_BITS = 24,
    parameter int ID_BITS    = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_tvalid,
    output logic      s_tready,
    // item_id, query_group, target_group, reverse_strand
    input  wire logic [((ID_BITS+2*GROUP_BITS+1+7)/8)*8-1:0] s_tdata,
    // first_item
    input  wire logic [0:0] s_tuser,
    output logic      m_tvalid,
    input  wire logic m_tready,
    // set_id, extended, prev_item, overflow
    output logic [((16+1+ID_BITS+1+7)/8)*8-1:0] m_tdata
);
    import sbc_pkg::*;

    localparam int AW    = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW    = $clog2(LIST_DEPTH + 1);
    localparam int EW    = SET_BITS + ID_BITS + 1 + 2*GROUP_BITS;
    localparam int OUT_W = ((SET_BITS+1+ID_BITS+1+7)/8)*8;
    localparam int OPAD  = OUT_W - (SET_BITS+1+ID_BITS+1);

    sbc_state_t state_reg, state_next;

    logic [ID_BITS-1:0]    id_reg;
    logic [GROUP_BITS-1:0] qg_reg, tg_reg;
    logic                  rev_reg;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [CW-1:0]         rd_reg, rd_next, wr_reg, wr_next;
    logic [SET_BITS-1:0]   nset_reg, nset_next;
    logic                  hit_reg, hit_next;
    logic [SET_BITS-1:0]   set_reg, set_next;
    logic [ID_BITS-1:0]    prev_reg, prev_next;
    logic                  ovf_reg, ovf_next;
    logic                  mv_reg, mv_next;
    logic [OUT_W-1:0]      md_reg, md_next;

    logic                  we, re;
    logic [AW-1:0]         waddr;
    logic [EW-1:0]         wdata, rdata;

    logic [GROUP_BITS-1:0] e_q, e_t;
    logic                  e_s;
    logic [SET_BITS-1:0]   e_set;
    logic [ID_BITS-1:0]    e_last;
    sbc_cmp_t              cmp;
    logic                  s_acc;
    logic [CW-1:0]         cnt_eff;

    assign {e_set, e_last, e_s, e_t, e_q} = rdata;
    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign cnt_eff  = s_tuser[0] ? '0 : cnt_reg;
    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;

    sbc_list_ram #(
        .DEPTH(LIST_DEPTH),
        .WIDTH(EW),
        .AW   (AW)
    ) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .re   (re),
        .raddr(rd_reg[AW-1:0]),
        .rdata(rdata)
    );

    sbc_match #(
        .GROUP_BITS(GROUP_BITS)
    ) u_match (
        .qg (qg_reg),
        .tg (tg_reg),
        .rev(rev_reg),
        .eq (e_q),
        .et (e_t),
        .es (e_s),
        .cmp(cmp)
    );

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rd_next    = rd_reg;
        wr_next    = wr_reg;
        nset_next  = nset_reg;
        hit_next   = hit_reg;
        set_next   = set_reg;
        prev_next  = prev_reg;
        ovf_next   = ovf_reg;
        mv_next    = mv_reg;
        md_next    = md_reg;
        we         = 1'b0;
        re         = 1'b0;
        waddr      = wr_reg[AW-1:0];
        wdata      = rdata;

        if (mv_reg && m_tready)
        begin
            mv_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_acc)
                begin
                    cnt_next  = cnt_eff;
                    nset_next = s_tuser[0] ? '0 : nset_reg;
                    rd_next   = '0;
                    wr_next   = '0;
                    hit_next  = 1'b0;
                    state_next = (cnt_eff == '0) ? S_FIN : S_RD;
                end
            end
            S_RD:
            begin
                re         = 1'b1;
                state_next = S_EV;
            end
            S_EV:
            begin
                rd_next = rd_reg + CW'(1);
                if (hit_reg)
                begin
                    we      = 1'b1;
                    wr_next = wr_reg + CW'(1);
                end
                else if (cmp.adj)
                begin
                    we        = 1'b1;
                    wdata     = {e_set, id_reg, e_s, tg_reg, qg_reg};
                    wr_next   = wr_reg + CW'(1);
                    hit_next  = 1'b1;
                    set_next  = e_set;
                    prev_next = e_last;
                end
                else if (cmp.far && (rd_reg + CW'(1) != cnt_reg))
                begin
                    // dropped: write pointer stays
                end
                else
                begin
                    we      = 1'b1;
                    wr_next = wr_reg + CW'(1);
                end
                state_next = (rd_reg + CW'(1) < cnt_reg) ? S_RD : S_FIN;
            end
            S_FIN:
            begin
                if (hit_reg)
                begin
                    cnt_next = wr_reg;
                    ovf_next = 1'b0;
                end
                else
                begin
                    set_next  = nset_reg;
                    prev_next = '0;
                    nset_next = nset_reg + SET_BITS'(1);
                    if (wr_reg < CW'(LIST_DEPTH))
                    begin
                        we       = 1'b1;
                        wdata    = {nset_reg, id_reg, rev_reg, tg_reg, qg_reg};
                        cnt_next = wr_reg + CW'(1);
                        ovf_next = 1'b0;
                    end
                    else
                    begin
                        cnt_next = wr_reg;
                        ovf_next = 1'b1;
                    end
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!mv_reg || m_tready)
                begin
                    mv_next    = 1'b1;
                    md_next    = {{OPAD{1'b0}}, ovf_reg, prev_reg, hit_reg, set_reg};
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            nset_reg  <= '0;
            mv_reg    <= 1'b0;
            rd_reg    <= '0;
            wr_reg    <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            nset_reg  <= nset_next;
            mv_reg    <= mv_next;
            rd_reg    <= rd_next;
            wr_reg    <= wr_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            id_reg  <= s_tdata[ID_BITS-1:0];
            qg_reg  <= s_tdata[ID_BITS +: GROUP_BITS];
            tg_reg  <= s_tdata[ID_BITS+GROUP_BITS +: GROUP_BITS];
            rev_reg <= s_tdata[ID_BITS+2*GROUP_BITS];
        end
        set_reg  <= set_next;
        prev_reg <= prev_next;
        ovf_reg  <= ovf_next;
        md_reg   <= md_next;
    end

endmodule

`default_nettype wire

// ===== tb/tb_synteny_block_chainer_core.sv =====
// Testbench for the synteny block chainer core: directed and random blocks, scoreboard check.
`timescale 1ns / 1ps

module tb_synteny_block_chainer_core;

    localparam int DEPTH  = 64;
    localparam int GBITS  = 24;
    localparam int IBITS  = 16;
    localparam int SW     = ((IBITS + 2 * GBITS + 1 + 7) / 8) * 8;
    localparam int MW     = ((16 + 1 + IBITS + 1 + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 2000000;

    // last member sits in the lowest bits
    typedef struct packed {
        logic        overflow;
        logic [15:0] prev_item;
        logic        extended;
        logic [15:0] set_id;
    } chain_result_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [SW-1:0] s_tdata;
    logic [0:0] s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [MW-1:0] m_tdata;

    synteny_block_chainer_core #(
        .LIST_DEPTH(DEPTH),
        .GROUP_BITS(GBITS),
        .ID_BITS(IBITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    // chain list shadow
    logic [GBITS-1:0] end_qg [DEPTH];
    logic [GBITS-1:0] end_tg [DEPTH];
    logic             end_rev [DEPTH];
    logic [15:0]      end_set [DEPTH];
    logic [IBITS-1:0] end_item [DEPTH];
    int               end_count;
    logic [15:0]      set_counter;

    chain_result_t pending_results[$];
    int errors;
    int cycles;
    int send_idle_pct;
    int recv_idle_pct;
    bit recv_hold;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic void remove_end(int k);
        for (int j = k; j + 1 < end_count; j++)
        begin
            end_qg[j]   = end_qg[j + 1];
            end_tg[j]   = end_tg[j + 1];
            end_rev[j]  = end_rev[j + 1];
            end_set[j]  = end_set[j + 1];
            end_item[j] = end_item[j + 1];
        end
        end_count--;
    endfunction

    function automatic chain_result_t chain_block(logic [IBITS-1:0] id, logic [GBITS-1:0] qg,
                                                  logic [GBITS-1:0] tg, logic rev, logic first);
        chain_result_t r;
        longint qd;
        longint td;
        bit adj;
        int i;
        i = 0;
        if (first)
        begin
            end_count = 0;
            set_counter = '0;
        end
        while (i < end_count)
        begin
            qd = longint'(qg) - longint'(end_qg[i]);
            td = longint'(tg) - longint'(end_tg[i]);
            adj = (qd == 1) && (rev == end_rev[i]) &&
                  ((td == 1 && !rev) || (td == -1 && rev));
            if (adj)
            begin
                r.set_id = end_set[i];
                r.extended = 1'b1;
                r.prev_item = end_item[i];
                r.overflow = 1'b0;
                end_qg[i] = qg;
                end_tg[i] = tg;
                end_item[i] = id;
                return r;
            end
            if (i + 1 >= end_count)
                break;
            if (qd > 1)
                remove_end(i);
            else
                i++;
        end
        r.set_id = set_counter;
        r.extended = 1'b0;
        r.prev_item = '0;
        if (end_count < DEPTH)
        begin
            end_qg[end_count] = qg;
            end_tg[end_count] = tg;
            end_rev[end_count] = rev;
            end_set[end_count] = set_counter;
            end_item[end_count] = id;
            end_count++;
            r.overflow = 1'b0;
        end
        else
            r.overflow = 1'b1;
        set_counter = set_counter + 16'd1;
        return r;
    endfunction

    // valid stays high into the next call so back-to-back words need no gap
    task automatic send_block(logic [IBITS-1:0] id, logic [GBITS-1:0] qg,
                              logic [GBITS-1:0] tg, logic rev, logic first);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tdata <= SW'({rev, tg, qg, id});
        s_tuser <= first;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(chain_block(id, qg, tg, rev, first));
        @(negedge clk);
    endtask

    // receiver ready
    always @(negedge clk)
    begin
        if (!rst_n || recv_hold)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        chain_result_t got;
        chain_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[$bits(chain_result_t)-1:0];
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected word %h", $time, got);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.set_id !== want.set_id)
                    $display("%0t: set_id exp %h got %h", $time, want.set_id, got.set_id);
                if (got.extended !== want.extended)
                    $display("%0t: extended exp %b got %b", $time, want.extended, got.extended);
                if (got.prev_item !== want.prev_item)
                    $display("%0t: prev_item exp %h got %h", $time, want.prev_item,
                             got.prev_item);
                if (got.overflow !== want.overflow)
                    $display("%0t: overflow exp %b got %b", $time, want.overflow, got.overflow);
                if (got !== want)
                    errors++;
            end
        end
    end

    task automatic test_directed();
        send_block(16'h0000, 24'h000000, 24'h000000, 1'b0, 1'b1);
        send_block(16'hFFFF, 24'h000001, 24'h000001, 1'b0, 1'b0);
        send_block(16'h1234, 24'hFFFFFE, 24'hFFFFFF, 1'b1, 1'b0);
        send_block(16'h5678, 24'hFFFFFF, 24'hFFFFFE, 1'b1, 1'b0);
        send_block(16'h0001, 24'h000002, 24'h000000, 1'b0, 1'b0);
        send_block(16'h0002, 24'h000010, 24'h000010, 1'b0, 1'b0);
        send_block(16'h0003, 24'h000011, 24'h00000F, 1'b0, 1'b0);
        send_block(16'h0004, 24'h000011, 24'h000011, 1'b1, 1'b0);
        send_block(16'h0005, 24'h000100, 24'h000100, 1'b0, 1'b0);
        send_block(16'h0006, 24'h000101, 24'h000101, 1'b0, 1'b0);
        send_block(16'hAAAA, 24'h000000, 24'hFFFFFF, 1'b1, 1'b1);
        send_block(16'h5555, 24'h000001, 24'hFFFFFE, 1'b1, 1'b0);
    endtask

    // fill past the list depth so overflow shows up
    task automatic test_overflow();
        send_block(16'h0100, 24'h000500, 24'h000000, 1'b0, 1'b1);
        for (int k = 0; k < DEPTH + 4; k++)
            send_block(IBITS'(k), 24'h000500, GBITS'(k * 7 + 100), k[0], 1'b0);
    endtask

    task automatic test_random(int n);
        logic [GBITS-1:0] qg;
        logic [GBITS-1:0] tg;
        logic rev;
        qg = GBITS'($urandom);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(9) < 8)
            begin
                // mostly walk nearby groups so chains extend
                qg = qg + GBITS'($urandom_range(2));
                rev = 1'($urandom_range(1));
                if ($urandom_range(2) == 0 && end_count > 0)
                begin
                    int e;
                    e = $urandom_range(end_count - 1);
                    rev = end_rev[e];
                    qg = end_qg[e] + GBITS'(1);
                    tg = rev ? end_tg[e] - GBITS'(1) : end_tg[e] + GBITS'(1);
                end
                else
                    tg = GBITS'($urandom_range(40));
            end
            else
            begin
                qg = GBITS'($urandom);
                tg = GBITS'($urandom);
                rev = 1'($urandom_range(1));
            end
            send_block(IBITS'($urandom), qg, tg, rev, ($urandom_range(199) == 0));
        end
    endtask

    task automatic test_backpressure();
        recv_hold = 1'b1;
        fork
            repeat (300) @(negedge clk);
            test_random(20);
        join_any
        recv_hold = 1'b0;
        wait fork;
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        errors = 0;
        cycles = 0;
        recv_hold = 1'b0;
        end_count = 0;
        set_counter = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_overflow();
        send_idle_pct = 22;
        recv_idle_pct = 66;
        test_random(650);
        test_backpressure();
        send_idle_pct = 66;
        recv_idle_pct = 22;
        test_random(600);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(600);
        s_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
